>>> rtl/core/afrlrc_pkg.sv
// shared types, constants and hex decode for the ascii frame receiver
`timescale 1ns / 1ps

package afrlrc_pkg;

  localparam int unsigned MAX_FRAME_CHARS = 1024;
  localparam int unsigned COUNT_W = 11;

  localparam logic [7:0] START_CHAR = 8'h3A;
  localparam logic [7:0] CR_CHAR    = 8'h0D;
  localparam logic [7:0] LF_CHAR    = 8'h0A;
  localparam logic [7:0] ALPHA_BASE = 8'h41;
  localparam logic [4:0] ALPHA_ADJ  = 5'h09;

  localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(MAX_FRAME_CHARS);

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_GOOD      = 2'd0,
    ST_LRC_BAD   = 2'd1,
    ST_MALFORMED = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  typedef struct packed {
    logic       emit;
    kind_t      kind;
    logic [7:0] data_byte;
    status_t    frame_status;
  } result_t;

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    v = {1'b0, c[3:0]};
    if (c >= ALPHA_BASE) begin
      v = v + ALPHA_ADJ;
    end
    return v;
  endfunction

endpackage

>>> rtl/core/ascii_frame_receiver_lrc_top.sv
// top level of the ascii frame receiver with lrc check
`timescale 1ns / 1ps

// Receives one character per cycle and emits decoded bytes and one status
// word at each frame end. A character passes an input register, then the
// frame logic, and any word that it yields is held in the result register;
// one character is accepted every cycle as long as the output side takes
// words. check_lrc is written through the config channel, which is always
// ready, and takes effect from the next character.

module ascii_frame_receiver_lrc_top
  import afrlrc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_char,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       check_lrc,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       kind,
  output logic [7:0] data_byte,
  output logic [1:0] frame_status
);

  logic       lrc_enable;
  logic       char_held;
  logic [7:0] char_q;
  logic       out_free;
  logic       step;
  result_t    res;

  assign cfg_ready = 1'b1;
  assign step      = char_held && out_free;
  assign in_stall  = char_held && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      lrc_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      lrc_enable <= check_lrc;
    end
  end

  afrlrc_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_char  (rx_char),
    .consume  (step),
    .held     (char_held),
    .char_q   (char_q)
  );

  afrlrc_frame u_frame (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .c          (char_q),
    .lrc_enable (lrc_enable),
    .res        (res)
  );

  afrlrc_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .res          (res),
    .out_stall    (out_stall),
    .out_free     (out_free),
    .out_valid    (out_valid),
    .kind         (kind),
    .data_byte    (data_byte),
    .frame_status (frame_status)
  );

  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output free");

  a_status_word_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_STATUS) |-> (data_byte == 8'h00))
    else $error("status word carries data");

  a_data_word_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_DATA) |-> (frame_status == ST_GOOD))
    else $error("data word carries status");

  a_result_follows_step: assert property (@(posedge clk) disable iff (rst)
    (!out_valid && !step) |=> !out_valid)
    else $error("word appeared without a character");

endmodule

>>> rtl/core/afrlrc_in_reg.sv
// input register holding one received character
`timescale 1ns / 1ps

module afrlrc_in_reg
  import afrlrc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] rx_char,
  input  logic       consume,
  output logic       held,
  output logic [7:0] char_q
);

  logic take;

  assign take = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (take) begin
      held <= 1'b1;
    end else if (consume) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      char_q <= rx_char;
    end
  end

endmodule

>>> rtl/core/afrlrc_frame.sv
// frame tracking, hex pairing, lrc sum and end of frame status
`timescale 1ns / 1ps

module afrlrc_frame
  import afrlrc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] c,
  input  logic       lrc_enable,
  output result_t    res
);

  logic               in_frame, in_frame_next;
  logic [COUNT_W-1:0] char_count, char_count_next;
  logic [7:0]         held_char, held_char_next;
  logic               held_valid, held_valid_next;
  logic [4:0]         high_nibble, high_nibble_next;
  logic               nibble_pending, nibble_pending_next;
  logic [7:0]         byte_sum, byte_sum_next;
  logic               any_pair, any_pair_next;
  logic [4:0]         lo;
  logic [7:0]         pair_byte;

  assign lo        = hex_val(held_char);
  assign pair_byte = {high_nibble[3:0], 4'b0000} | {3'b000, lo};

  always_comb begin
    in_frame_next       = in_frame;
    char_count_next     = char_count;
    held_char_next      = held_char;
    held_valid_next     = held_valid;
    high_nibble_next    = high_nibble;
    nibble_pending_next = nibble_pending;
    byte_sum_next       = byte_sum;
    any_pair_next       = any_pair;
    res.emit            = 1'b0;
    res.kind            = KIND_DATA;
    res.data_byte       = 8'h00;
    res.frame_status    = ST_GOOD;

    if (!in_frame) begin
      if (c == START_CHAR) begin
        in_frame_next       = 1'b1;
        char_count_next     = COUNT_W'(1);
        held_char_next      = 8'h00;
        held_valid_next     = 1'b0;
        high_nibble_next    = 5'd0;
        nibble_pending_next = 1'b0;
        byte_sum_next       = 8'h00;
        any_pair_next       = 1'b0;
      end
    end else if (char_count >= COUNT_LIMIT ||
                 (held_valid && held_char == CR_CHAR && c == LF_CHAR)) begin
      res.emit = 1'b1;
      res.kind = KIND_STATUS;
      if (char_count >= COUNT_LIMIT) begin
        res.frame_status = ST_OVERFLOW;
      end else if (lrc_enable) begin
        if (nibble_pending || !any_pair) begin
          res.frame_status = ST_MALFORMED;
        end else if (byte_sum != 8'h00) begin
          res.frame_status = ST_LRC_BAD;
        end
      end
      in_frame_next       = 1'b0;
      char_count_next     = '0;
      held_char_next      = 8'h00;
      held_valid_next     = 1'b0;
      high_nibble_next    = 5'd0;
      nibble_pending_next = 1'b0;
      byte_sum_next       = 8'h00;
      any_pair_next       = 1'b0;
    end else begin
      char_count_next = char_count + COUNT_W'(1);
      held_char_next  = c;
      held_valid_next = 1'b1;
      if (held_valid) begin
        if (!nibble_pending) begin
          high_nibble_next    = lo;
          nibble_pending_next = 1'b1;
        end else begin
          nibble_pending_next = 1'b0;
          any_pair_next       = 1'b1;
          byte_sum_next       = byte_sum + pair_byte;
          res.emit            = 1'b1;
          res.data_byte       = pair_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame       <= 1'b0;
      char_count     <= '0;
      held_char      <= 8'h00;
      held_valid     <= 1'b0;
      high_nibble    <= 5'd0;
      nibble_pending <= 1'b0;
      byte_sum       <= 8'h00;
      any_pair       <= 1'b0;
    end else if (step) begin
      in_frame       <= in_frame_next;
      char_count     <= char_count_next;
      held_char      <= held_char_next;
      held_valid     <= held_valid_next;
      high_nibble    <= high_nibble_next;
      nibble_pending <= nibble_pending_next;
      byte_sum       <= byte_sum_next;
      any_pair       <= any_pair_next;
    end
  end

endmodule

>>> rtl/core/afrlrc_out_reg.sv
// result register driving the output word channel
`timescale 1ns / 1ps

module afrlrc_out_reg
  import afrlrc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  result_t    res,
  input  logic       out_stall,
  output logic       out_free,
  output logic       out_valid,
  output logic       kind,
  output logic [7:0] data_byte,
  output logic [1:0] frame_status
);

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && step && res.emit) begin
      kind         <= res.kind;
      data_byte    <= res.data_byte;
      frame_status <= res.frame_status;
    end
  end

endmodule

>>> tb/tb.sv
// self-checking testbench for the ascii frame receiver: directed, overflow and random frames
`timescale 1ns / 1ps

module tb;
  import afrlrc_pkg::*;

  localparam int unsigned STALL_PCT      = 34;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned REPORT_LIMIT   = 10;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    status_t    frame_status;
  } word_t;

  typedef logic [7:0] char_q_t[$];

  typedef enum logic [2:0] {
    FR_GOOD,
    FR_BAD_LRC,
    FR_ODD,
    FR_JUNK,
    FR_NOISE
  } shape_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] rx_char = 8'h00;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       check_lrc = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       kind;
  logic [7:0] data_byte;
  logic [1:0] frame_status;

  // frame tracker state
  bit          lrc_on = 1'b0;
  bit          frame_open = 1'b0;
  bit          held_ok = 1'b0;
  bit          nib_wait = 1'b0;
  bit          got_pair = 1'b0;
  logic [10:0] n_chars = '0;
  logic [7:0]  held_c = '0;
  logic [7:0]  lrc_sum = '0;
  logic [4:0]  hi_nib = '0;

  word_t       expected_words[$];
  int unsigned frame_chars = 0;
  int unsigned bad_words = 0;
  bit          idle_on = 1'b1;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  always #5 clk = ~clk;

  ascii_frame_receiver_lrc_top u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_char      (rx_char),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .check_lrc    (check_lrc),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .data_byte    (data_byte),
    .frame_status (frame_status)
  );

  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    logic [4:0] adj;
    adj = (c >= ALPHA_BASE) ? ALPHA_ADJ : 5'd0;
    return {1'b0, c[3:0]} + adj;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit lower);
    if (v < 4'd10) begin
      return "0" + 8'(v);
    end
    return (lower ? "a" : "A") + 8'(v) - 8'd10;
  endfunction

  function automatic void clear_frame();
    n_chars = '0;
    held_c = '0;
    held_ok = 1'b0;
    hi_nib = '0;
    nib_wait = 1'b0;
    lrc_sum = '0;
    got_pair = 1'b0;
  endfunction

  function automatic void end_frame(input status_t st);
    expected_words.push_back('{kind: KIND_STATUS, data_byte: 8'h00, frame_status: st});
    frame_open = 1'b0;
    clear_frame();
  endfunction

  // advance the frame tracker by one accepted character
  task automatic track_char(input logic [7:0] c);
    logic [7:0] prev;
    logic [8:0] wide;
    bit         had;
    status_t    st;
    if (!frame_open) begin
      if (c == START_CHAR) begin
        clear_frame();
        frame_open = 1'b1;
        n_chars = 11'd1;
        frame_chars++;
      end
      return;
    end
    frame_chars++;
    if (n_chars >= COUNT_LIMIT) begin
      end_frame(ST_OVERFLOW);
      return;
    end
    n_chars = n_chars + 11'd1;
    if (held_ok && held_c == CR_CHAR && c == LF_CHAR) begin
      st = ST_GOOD;
      if (lrc_on) begin
        if (nib_wait || !got_pair) begin
          st = ST_MALFORMED;
        end else if (lrc_sum != 8'h00) begin
          st = ST_LRC_BAD;
        end
      end
      end_frame(st);
      return;
    end
    prev = held_c;
    had = held_ok;
    held_c = c;
    held_ok = 1'b1;
    if (!had) begin
      return;
    end
    if (!nib_wait) begin
      hi_nib = nibble_of(prev);
      nib_wait = 1'b1;
      return;
    end
    wide = {hi_nib, 4'h0} | {4'h0, nibble_of(prev)};
    nib_wait = 1'b0;
    got_pair = 1'b1;
    lrc_sum = lrc_sum + wide[7:0];
    expected_words.push_back('{kind: KIND_DATA, data_byte: wide[7:0], frame_status: ST_GOOD});
  endtask

  task automatic send_char(input logic [7:0] c);
    while (idle_on && $urandom_range(99) < STALL_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_char <= c;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    track_char(c);
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_char(s[i]);
  endtask

  task automatic send_crlf();
    send_char(CR_CHAR);
    send_char(LF_CHAR);
  endtask

  // random characters inside a frame, never a cr so the frame cannot close
  task automatic send_filler(input int unsigned n);
    logic [7:0] c;
    repeat (n) begin
      do c = 8'($urandom); while (c == CR_CHAR);
      send_char(c);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_check(input bit v);
    wait_drained();
    cfg_valid <= 1'b1;
    check_lrc <= v;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
    lrc_on = v;
  endtask

  task automatic send_random_frame();
    char_q_t     body;
    logic [7:0]  b;
    logic [7:0]  sum;
    int unsigned n;
    int unsigned r;
    bit          lower;
    shape_t      shape;
    r = $urandom_range(99);
    shape = (r < 60) ? FR_GOOD : (r < 70) ? FR_BAD_LRC : (r < 78) ? FR_ODD :
            (r < 90) ? FR_JUNK : FR_NOISE;
    if (shape == FR_NOISE) begin
      n = $urandom_range(1, 6);
      repeat (n) send_char(8'($urandom));
      return;
    end
    if (shape == FR_JUNK) begin
      n = $urandom_range(0, 12);
      repeat (n) begin
        case ($urandom_range(7))
          0: body.push_back(CR_CHAR);
          1: body.push_back(LF_CHAR);
          2: body.push_back(START_CHAR);
          default: body.push_back(8'($urandom));
        endcase
      end
    end else begin
      lower = 1'($urandom_range(1));
      sum = 8'h00;
      n = $urandom_range(1, 8);
      repeat (n) begin
        b = 8'($urandom);
        sum = sum + b;
        body.push_back(hex_char(b[7:4], lower));
        body.push_back(hex_char(b[3:0], lower));
      end
      b = 8'h00 - sum;
      if (shape == FR_BAD_LRC) begin
        b = b + 8'($urandom_range(1, 255));
      end
      body.push_back(hex_char(b[7:4], lower));
      body.push_back(hex_char(b[3:0], lower));
      if (shape == FR_ODD) begin
        body.delete($urandom_range(body.size() - 1));
      end
    end
    send_char(START_CHAR);
    foreach (body[i]) send_char(body[i]);
    send_crlf();
  endtask

  task automatic run_frames(input int unsigned n);
    int unsigned stop;
    stop = frame_chars + n;
    while (frame_chars < stop) send_random_frame();
  endtask

  task automatic test_directed();
    write_check(1'b1);
    send_char(8'h00);
    send_char(8'hFF);
    send_text(":0102FD");
    send_crlf();
    send_text(":FF");
    send_crlf();
    send_text(":1");
    send_crlf();
    send_char(START_CHAR);
    send_crlf();
    // lone cr, start mark inside a frame, lone lf
    send_char(START_CHAR);
    send_char(CR_CHAR);
    send_char(START_CHAR);
    send_char(LF_CHAR);
    send_char(CR_CHAR);
    send_crlf();
  endtask

  task automatic test_overflow();
    send_char(START_CHAR);
    send_filler(1021);
    send_crlf();
    send_char(START_CHAR);
    send_filler(1022);
    send_crlf();
    // the dropped character is a start mark and must not open a frame
    send_char(START_CHAR);
    send_filler(1023);
    send_char(START_CHAR);
    send_text("00");
    send_crlf();
    send_text(":0102FD");
    send_crlf();
  endtask

  task automatic test_unchecked();
    write_check(1'b0);
    send_text(":FF");
    send_crlf();
    send_text(":1");
    send_crlf();
    run_frames(50);
  endtask

  task automatic test_random();
    write_check(1'b1);
    run_frames(200);
    write_check(1'b0);
    run_frames(80);
    write_check(1'b1);
    run_frames(120);
  endtask

  task automatic test_no_idle();
    idle_on = 1'b0;
    run_frames(120);
    idle_on = 1'b1;
  endtask

  task automatic test_backpressure();
    hold_left = HOLD_CYCLES;
    run_frames(80);
  endtask

  // output checker and output stall
  always @(posedge clk) begin
    word_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_words.size() == 0) begin
        if (bad_words < REPORT_LIMIT) begin
          $display("unexpected word: kind %0d byte %02h status %0d",
                   kind, data_byte, frame_status);
        end
        bad_words++;
      end else begin
        want = expected_words.pop_front();
        if (kind !== want.kind || data_byte !== want.data_byte ||
            frame_status !== want.frame_status) begin
          if (bad_words < REPORT_LIMIT) begin
            $display("mismatch: expected kind %0d byte %02h status %0d",
                     want.kind, want.data_byte, want.frame_status);
            $display("          got kind %0d byte %02h status %0d",
                     kind, data_byte, frame_status);
          end
          bad_words++;
        end
      end
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= idle_on && ($urandom_range(99) < STALL_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_overflow();
    test_unchecked();
    test_random();
    test_no_idle();
    test_backpressure();
    wait_drained();
    if (bad_words == 0 && expected_words.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
